// ===== hw/rtl/aat_pkg.sv =====
// Shared constants and types for the axis-aligned box affine transform block.
package aat_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEFF_WIDTH_DEF = 16;
   localparam int COEFF_INT_BITS  = 4;
   localparam int NUM_AXES        = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_ADDR_WIDTH  = 6;
   localparam int CSR_BYTE_BITS   = 3;

   typedef enum logic [CSR_ADDR_WIDTH-CSR_BYTE_BITS-1:0] {
      REG_ROW_X,
      REG_ROW_Y,
      REG_ROW_Z,
      REG_SHIFT_X,
      REG_SHIFT_Y,
      REG_SHIFT_Z
   } reg_index_type;

endpackage

// ===== hw/rtl/aat_csr.sv =====
// Configuration register file: coefficient rows and translations behind an APB-style port.
module aat_csr import aat_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]           csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]           csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]           csr_prdata,
   output logic                                csr_pready,
   output logic [3*COEFF_WIDTH-1:0]            rows [NUM_AXES],
   output logic signed [COORD_WIDTH-1:0]       shifts [NUM_AXES]
);

   localparam int ROW_WIDTH = 3 * COEFF_WIDTH;
   localparam int FRAC      = COEFF_WIDTH - COEFF_INT_BITS;
   localparam logic [CSR_DATA_WIDTH-1:0] ONE = CSR_DATA_WIDTH'(1) << FRAC;

   logic [ROW_WIDTH-1:0]         row_ff   [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] shift_ff [NUM_AXES];
   reg_index_type                index;
   logic                         write;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_BYTE_BITS]);
   assign write      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= ROW_WIDTH'(ONE);
         row_ff[1]   <= ROW_WIDTH'(ONE << COEFF_WIDTH);
         row_ff[2]   <= ROW_WIDTH'(ONE << (2 * COEFF_WIDTH));
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (write) begin
         case (index)
            REG_ROW_X:   row_ff[0]   <= ROW_WIDTH'(csr_pwdata);
            REG_ROW_Y:   row_ff[1]   <= ROW_WIDTH'(csr_pwdata);
            REG_ROW_Z:   row_ff[2]   <= ROW_WIDTH'(csr_pwdata);
            REG_SHIFT_X: shift_ff[0] <= COORD_WIDTH'(csr_pwdata);
            REG_SHIFT_Y: shift_ff[1] <= COORD_WIDTH'(csr_pwdata);
            REG_SHIFT_Z: shift_ff[2] <= COORD_WIDTH'(csr_pwdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ROW_X:   csr_prdata = CSR_DATA_WIDTH'(row_ff[0]);
         REG_ROW_Y:   csr_prdata = CSR_DATA_WIDTH'(row_ff[1]);
         REG_ROW_Z:   csr_prdata = CSR_DATA_WIDTH'(row_ff[2]);
         REG_SHIFT_X: csr_prdata = CSR_DATA_WIDTH'(shift_ff[0]);
         REG_SHIFT_Y: csr_prdata = CSR_DATA_WIDTH'(shift_ff[1]);
         REG_SHIFT_Z: csr_prdata = CSR_DATA_WIDTH'(shift_ff[2]);
         default:     csr_prdata = '0;
      endcase
   end

   assign rows   = row_ff;
   assign shifts = shift_ff;

endmodule

// ===== hw/rtl/aabb_affine_transform.sv =====
// Top level of the axis-aligned box affine transform pipeline.
// This block takes one box per beat and returns the axis-aligned bound of the box mapped
// through the configured 3x3 matrix and translation. It accepts one beat every clock cycle
// unless the input side is stopped, and each result passes through four register
// stages: operand selection, multiplication, summation with rounding, and translation with
// saturation. A stalled output holds its beat while the earlier stages keep filling any empty
// slots, so the input side stops only when all four stages are occupied.
module aabb_affine_transform import aat_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_low_x,
   input  logic signed [COORD_WIDTH-1:0] req_low_y,
   input  logic signed [COORD_WIDTH-1:0] req_low_z,
   input  logic signed [COORD_WIDTH-1:0] req_high_x,
   input  logic signed [COORD_WIDTH-1:0] req_high_y,
   input  logic signed [COORD_WIDTH-1:0] req_high_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_low_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_low_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_low_z,
   output logic signed [COORD_WIDTH-1:0] rsp_out_high_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_high_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_high_z,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                          csr_pready
);

   localparam int ROW_WIDTH = 3 * COEFF_WIDTH;
   localparam int FRAC      = COEFF_WIDTH - COEFF_INT_BITS;
   localparam int PROD_W    = COORD_WIDTH + COEFF_WIDTH;
   localparam int SUM_W     = PROD_W + 2;
   localparam int RND_W     = SUM_W - FRAC;
   localparam int TOT_W     = RND_W + 1;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC - 1);

   logic [ROW_WIDTH-1:0]          rows   [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] shifts [NUM_AXES];
   logic signed [COEFF_WIDTH-1:0] coef   [NUM_AXES][3];
   logic signed [COORD_WIDTH-1:0] lo     [3];
   logic signed [COORD_WIDTH-1:0] hi     [3];

   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic                          en1, en2, en3, en4;

   logic signed [COORD_WIDTH-1:0] opnd_in  [NUM_AXES][2][3];
   logic signed [COORD_WIDTH-1:0] opnd_ff  [NUM_AXES][2][3];
   logic signed [PROD_W-1:0]      prod_in  [NUM_AXES][2][3];
   logic signed [PROD_W-1:0]      prod_ff  [NUM_AXES][2][3];
   logic signed [SUM_W-1:0]       sum_in   [NUM_AXES][2];
   logic signed [SUM_W-1:0]       sum_ff   [NUM_AXES][2];
   logic signed [COORD_WIDTH-1:0] res_in   [NUM_AXES][2];
   logic signed [COORD_WIDTH-1:0] res_ff   [NUM_AXES][2];

   aat_csr #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rows        (rows),
      .shifts      (shifts)
   );

   assign lo[0] = req_low_x;
   assign lo[1] = req_low_y;
   assign lo[2] = req_low_z;
   assign hi[0] = req_high_x;
   assign hi[1] = req_high_y;
   assign hi[2] = req_high_z;

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef[r][k] = rows[r][k*COEFF_WIDTH +: COEFF_WIDTH];
         end
      end
   end

   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // The bound of each term takes the corner coordinate that gives the smaller or larger product.
   always_comb begin
      logic low_smaller;
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int k = 0; k < 3; k++) begin
            low_smaller = (!coef[r][k][COEFF_WIDTH-1]) == (lo[k] <= hi[k]);
            opnd_in[r][0][k] = low_smaller ? lo[k] : hi[k];
            opnd_in[r][1][k] = low_smaller ? hi[k] : lo[k];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < 3; k++) begin
               prod_in[r][b][k] = PROD_W'(opnd_ff[r][b][k]) * PROD_W'(coef[r][k]);
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int b = 0; b < 2; b++) begin
            sum_in[r][b] = SUM_W'(prod_ff[r][b][0]) + SUM_W'(prod_ff[r][b][1])
                         + SUM_W'(prod_ff[r][b][2]) + ROUND_HALF;
         end
      end
   end

   always_comb begin
      logic signed [TOT_W-1:0]         tot;
      logic [TOT_W-COORD_WIDTH:0]      top_bits;
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int b = 0; b < 2; b++) begin
            tot = TOT_W'($signed(sum_ff[r][b][SUM_W-1:FRAC])) + TOT_W'(shifts[r]);
            top_bits = tot[TOT_W-1:COORD_WIDTH-1];
            if ((&top_bits) || !(|top_bits)) begin
               res_in[r][b] = tot[COORD_WIDTH-1:0];
            end else if (tot[TOT_W-1]) begin
               res_in[r][b] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
               res_in[r][b] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) opnd_ff <= opnd_in;
      if (en2) prod_ff <= prod_in;
      if (en3) sum_ff  <= sum_in;
      if (en4) res_ff  <= res_in;
   end

   assign rsp_valid      = v4_ff;
   assign rsp_out_low_x  = res_ff[0][0];
   assign rsp_out_low_y  = res_ff[1][0];
   assign rsp_out_low_z  = res_ff[2][0];
   assign rsp_out_high_x = res_ff[0][1];
   assign rsp_out_high_y = res_ff[1][1];
   assign rsp_out_high_z = res_ff[2][1];

   a_ordered_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_low_x <= rsp_out_high_x) && (rsp_out_low_y <= rsp_out_high_y)
                    && (rsp_out_low_z <= rsp_out_high_z))
      else $error("result box has a low corner above its high corner");

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready)
      else $error("input held off while the pipeline has an empty stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !en2) |=> v1_ff && $stable(opnd_ff[0][0][0]))
      else $error("first stage dropped or changed a stalled beat");

endmodule

// ===== dv/aabb_affine_transform_tb.sv =====
// Self-checking testbench for the axis-aligned box affine transform block.
`timescale 1ns / 100ps

module aabb_affine_transform_tb;
   import aat_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int KW = COEFF_WIDTH_DEF;
   localparam int FRAC = KW - COEFF_INT_BITS;
   localparam int CYCLE_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int DIR_N = 16;
   localparam int DIR_TYPED_N = 8;
   localparam int NUM_CHUNKS = 4;
   localparam logic [CSR_ADDR_WIDTH-CSR_BYTE_BITS-1:0] REG_SPARE_IDX = 3'd6;
   localparam logic signed [CW-1:0] MINC = 32'sh8000_0000;
   localparam logic signed [CW-1:0] MAXC = 32'sh7FFF_FFFF;
   localparam logic signed [CW-1:0] ALT_A = 32'shAAAA_AAAA;
   localparam logic signed [CW-1:0] ALT_5 = 32'sh5555_5555;

   typedef struct packed {
      logic signed [CW-1:0] low_x;
      logic signed [CW-1:0] low_y;
      logic signed [CW-1:0] low_z;
      logic signed [CW-1:0] high_x;
      logic signed [CW-1:0] high_y;
      logic signed [CW-1:0] high_z;
   } box_type;

   typedef struct packed {
      box_type stim;
      logic typed;
      box_type golden;
   } box_case_type;

   typedef enum {CFG_RANDOM, CFG_TOP, CFG_BOTTOM} cfg_style_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   box_type req_box;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_out_low_x, rsp_out_low_y, rsp_out_low_z;
   logic signed [CW-1:0] rsp_out_high_x, rsp_out_high_y, rsp_out_high_z;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   logic [CSR_DATA_WIDTH-1:0] row_cfg [NUM_AXES];
   logic signed [CW-1:0] shift_cfg [NUM_AXES];
   box_type expected_boxes [$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   box_case_type dir_cases [DIR_N] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
      '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b1, '{MINC, MINC, MINC, MAXC, MAXC, MAXC}},
      '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 1'b1, '{MINC, MINC, MINC, MAXC, MAXC, MAXC}},
      '{'{1, -2, 3, 4, 5, 6}, 1'b1, '{1, -2, 3, 4, 5, 6}},
      '{'{5, -1, 65536, -5, 1, -65536}, 1'b1, '{-5, -1, -65536, 5, 1, 65536}},
      '{'{-1, -1, -1, -1, -1, -1}, 1'b1, '{-1, -1, -1, -1, -1, -1}},
      '{'{ALT_A, ALT_A, ALT_A, ALT_5, ALT_5, ALT_5}, 1'b1,
        '{ALT_A, ALT_A, ALT_A, ALT_5, ALT_5, ALT_5}},
      '{'{ALT_5, ALT_5, ALT_5, ALT_A, ALT_A, ALT_A}, 1'b1,
        '{ALT_A, ALT_A, ALT_A, ALT_5, ALT_5, ALT_5}},
      '{'{0, 0, 1, 0, 0, 1}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, -1, 0, 0, -1}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{1, 1, 1, 1, 1, 1}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 1, 1, 1}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{-3, 3, 65537, 3, -3, -65537}, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{'{65536, -65536, 7, 131072, 0, 9}, 1'b0, '{0, 0, 0, 0, 0, 0}}
   };

   int chunk_items [NUM_CHUNKS] = '{150, 380, 350, 150};
   cfg_style_type chunk_style [NUM_CHUNKS] = '{CFG_TOP, CFG_RANDOM, CFG_RANDOM, CFG_BOTTOM};
   int chunk_idle [NUM_CHUNKS] = '{20, 60, 0, 0};
   int chunk_stall [NUM_CHUNKS] = '{60, 20, 0, 0};

   aabb_affine_transform u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_low_x      (req_box.low_x),
      .req_low_y      (req_box.low_y),
      .req_low_z      (req_box.low_z),
      .req_high_x     (req_box.high_x),
      .req_high_y     (req_box.high_y),
      .req_high_z     (req_box.high_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_low_x  (rsp_out_low_x),
      .rsp_out_low_y  (rsp_out_low_y),
      .rsp_out_low_z  (rsp_out_low_z),
      .rsp_out_high_x (rsp_out_high_x),
      .rsp_out_high_y (rsp_out_high_y),
      .rsp_out_high_z (rsp_out_high_z),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The bound of each axis picks, per column, the smaller or larger of the two products,
   // sums at full precision, rounds half up at the coefficient fraction, then shifts and clamps.
   function automatic logic signed [CW-1:0] axis_bound(int axis, box_type b, bit want_max);
      logic signed [CW-1:0] lo [NUM_AXES];
      logic signed [CW-1:0] hi [NUM_AXES];
      logic signed [KW-1:0] c16;
      logic signed [63:0] coef, p_lo, p_hi, acc, sh, r;
      lo = '{b.low_x, b.low_y, b.low_z};
      hi = '{b.high_x, b.high_y, b.high_z};
      acc = 64'sd0;
      for (int k = 0; k < NUM_AXES; k++) begin
         c16 = row_cfg[axis][KW*k +: KW];
         coef = c16;
         p_lo = lo[k];
         p_hi = hi[k];
         p_lo = p_lo * coef;
         p_hi = p_hi * coef;
         if (want_max) begin
            acc = acc + ((p_lo > p_hi) ? p_lo : p_hi);
         end else begin
            acc = acc + ((p_lo < p_hi) ? p_lo : p_hi);
         end
      end
      sh = shift_cfg[axis];
      r = ((acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC) + sh;
      if (r > 64'(MAXC)) r = MAXC;
      if (r < 64'(MINC)) r = MINC;
      return r[CW-1:0];
   endfunction

   function automatic box_type transform_box(box_type b);
      box_type r;
      r.low_x = axis_bound(0, b, 1'b0);
      r.low_y = axis_bound(1, b, 1'b0);
      r.low_z = axis_bound(2, b, 1'b0);
      r.high_x = axis_bound(0, b, 1'b1);
      r.high_y = axis_bound(1, b, 1'b1);
      r.high_z = axis_bound(2, b, 1'b1);
      return r;
   endfunction

   function automatic void report(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   function automatic void check_field(string name, logic signed [CW-1:0] want,
                                       logic signed [CW-1:0] seen);
      if (seen !== want) begin
         report($sformatf("mismatch on %s: expected %0d (%h), got %0d (%h)",
                          name, want, want, seen, seen));
      end
   endfunction

   function automatic logic signed [CW-1:0] random_coord();
      logic signed [CW-1:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: v = MINC;
               1: v = MAXC;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         1, 2, 3: begin
            v = $urandom_range(0, 32'h000F_FFFF);
            v = v - 32'sh0008_0000;
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic box_type random_box();
      box_type b;
      logic signed [CW-1:0] a [NUM_AXES];
      logic signed [CW-1:0] z [NUM_AXES];
      for (int k = 0; k < NUM_AXES; k++) begin
         a[k] = random_coord();
         z[k] = random_coord();
         if ($urandom_range(9) < 7 && a[k] > z[k]) begin
            a[k] = z[k];
            z[k] = random_coord();
            if (z[k] < a[k]) z[k] = a[k];
         end
      end
      b.low_x = a[0];
      b.low_y = a[1];
      b.low_z = a[2];
      b.high_x = z[0];
      b.high_y = z[1];
      b.high_z = z[2];
      return b;
   endfunction

   function automatic logic [KW-1:0] random_coeff();
      logic [KW-1:0] c;
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(4))
               0: c = '0;
               1: c = 16'h8000;
               2: c = 16'h7FFF;
               3: c = 16'h1000;
               default: c = 16'hF000;
            endcase
         end
         1: c = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
         default: c = 16'($urandom());
      endcase
      return c;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aabb_affine_transform_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      box_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_out_low_x, rsp_out_low_y, rsp_out_low_z,
                  rsp_out_high_x, rsp_out_high_y, rsp_out_high_z};
         if (expected_boxes.size() == 0) begin
            report($sformatf("result beat with nothing expected: %h", seen));
         end else begin
            want = expected_boxes.pop_front();
            check_field("out_low_x", want.low_x, seen.low_x);
            check_field("out_low_y", want.low_y, seen.low_y);
            check_field("out_low_z", want.low_z, seen.low_z);
            check_field("out_high_x", want.high_x, seen.high_x);
            check_field("out_high_y", want.high_y, seen.high_y);
            check_field("out_high_z", want.high_z, seen.high_z);
         end
      end
   end

   task automatic send_box(box_type b, logic typed, box_type golden);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_box <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_boxes.push_back(typed ? golden : transform_box(b));
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_WIDTH-CSR_BYTE_BITS-1:0] idx,
                            logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, {CSR_BYTE_BITS{1'b0}}};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_ROW_X: row_cfg[0] = data;
         REG_ROW_Y: row_cfg[1] = data;
         REG_ROW_Z: row_cfg[2] = data;
         REG_SHIFT_X: shift_cfg[0] = data[CW-1:0];
         REG_SHIFT_Y: shift_cfg[1] = data[CW-1:0];
         REG_SHIFT_Z: shift_cfg[2] = data[CW-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(cfg_style_type style);
      logic [CSR_DATA_WIDTH-1:0] row, shift;
      for (int i = 0; i < NUM_AXES; i++) begin
         case (style)
            CFG_TOP: row = {16'($urandom()), 16'h7FFF, 16'h7FFF, 16'h7FFF};
            CFG_BOTTOM: row = {16'($urandom()), 16'h8000, 16'h8000, 16'h8000};
            default: row = {16'($urandom()), random_coeff(), random_coeff(), random_coeff()};
         endcase
         csr_write(reg_index_type'(REG_ROW_X + i), row);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         shift = {32'($urandom()), 32'($urandom())};
         case (style)
            CFG_TOP: shift[CW-1:0] = MAXC;
            CFG_BOTTOM: shift[CW-1:0] = MINC;
            default: if ($urandom_range(4) == 0) shift[CW-1:0] = '0;
         endcase
         csr_write(reg_index_type'(REG_SHIFT_X + i), shift);
      end
      csr_write(REG_SPARE_IDX, {32'($urandom()), 32'($urandom())});
      csr_release();
   endtask

   initial begin
      box_type none;
      none = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_box <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      row_cfg[0] = 64'h0000_0000_0000_1000;
      row_cfg[1] = 64'h0000_0000_1000_0000;
      row_cfg[2] = 64'h0000_1000_0000_0000;
      shift_cfg = '{0, 0, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      stall_pct = 60;
      for (int i = 0; i < DIR_N; i++) begin
         if (i == DIR_TYPED_N) begin
            // Column 0 at -8.0 and column 2 at 0.5, which gives rounding ties; row y is all zero.
            settle_block();
            csr_write(REG_ROW_X, 64'hFFFF_0800_0000_8000);
            csr_write(REG_ROW_Y, 64'h0000_0000_0000_0000);
            csr_write(REG_ROW_Z, 64'h0000_7FFF_7FFF_7FFF);
            csr_write(REG_SHIFT_X, 64'h0000_0000_0000_0000);
            csr_write(REG_SHIFT_Y, 64'hFFFF_FFFF_8000_0000);
            csr_write(REG_SHIFT_Z, 64'h1234_5678_7FFF_FFFF);
            csr_write(REG_SPARE_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
            csr_release();
         end
         send_box(dir_cases[i].stim, dir_cases[i].typed, dir_cases[i].golden);
      end

      for (int c = 0; c < NUM_CHUNKS; c++) begin
         settle_block();
         load_config(chunk_style[c]);
         send_idle_pct = chunk_idle[c];
         stall_pct = chunk_stall[c];
         for (int n = 0; n < chunk_items[c]; n++) begin
            if (c == 1 && n == 190) settle_block();
            send_box(random_box(), 1'b0, none);
         end
      end

      settle_block();
      if (fail_count == 0) begin
         $display("aabb_affine_transform_tb OK");
      end else begin
         $display("aabb_affine_transform_tb NOT OK");
      end
      $finish;
   end

endmodule
